// File: rtl/lftdb_pkg.sv
// ----------------------------------------------------------------------------
// lftdb_pkg
// Shared types and constants for the latest-frame transmit double buffer.
// ----------------------------------------------------------------------------
package lftdb_pkg;

  localparam int FRAME_BYTES_DEF = 16;
  localparam int BANK_COUNT      = 3;

  typedef logic [1:0] sel_t;

  localparam sel_t ACTIVE_SEL_RST  = 2'd0;
  localparam sel_t PENDING_SEL_RST = 2'd1;
  localparam sel_t STAGING_SEL_RST = 2'd2;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  // Result fields other than the byte, which comes from the bank memory.
  typedef struct packed {
    logic        tx_valid;
    logic        frame_done;
    logic        busy;
    logic [31:0] frames_sent;
    logic [31:0] frames_overwritten;
  } meta_t;

endpackage

// File: rtl/latest_frame_tx_double_buffer.sv
// ----------------------------------------------------------------------------
// latest_frame_tx_double_buffer
// Frame transmitter with staging, pending and active banks; newest frame wins.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload                     | role
//  --------+--------------------------+-----------------------------+----------------------
//  in      | in_valid_i, in_stall_o   | operation_i, data_byte_i    | submit byte / UART tick
//  out     | out_valid_o, out_stall_i | tx_*_o, frame_done_o, busy_res_o, frames_*_o
//
// One request per clock while the output is not stalled; a request passes the
// bank RAM read stage, then the output register. Each request makes at most one
// access to the bank RAM. Reset clears selectors, indices, flags and counters;
// bank contents stay undefined and need no clearing pass. A stalled output holds
// in the output register while one more request waits in the read stage;
// in_stall_o rises only when both are occupied.
module latest_frame_tx_double_buffer
  import lftdb_pkg::*;
#(
  parameter int FrameBytes = FRAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        frame_done_o,
  output logic        busy_res_o,
  output logic [31:0] frames_sent_o,
  output logic [31:0] frames_overwritten_o
);

  localparam int Depth = BANK_COUNT * FrameBytes;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int IW    = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;

  localparam logic [IW-1:0] LastIdx = IW'(FrameBytes - 1);

  sel_t          act_sel_q, act_sel_d;
  sel_t          pend_sel_q, pend_sel_d;
  sel_t          stg_sel_q, stg_sel_d;
  logic [IW-1:0] send_idx_q, send_idx_d;
  logic [IW-1:0] fill_idx_q, fill_idx_d;
  logic          active_full_q, active_full_d;
  logic          pending_full_q, pending_full_d;
  logic [31:0]   sent_cnt_q, sent_cnt_d;
  logic [31:0]   ovw_cnt_q, ovw_cnt_d;

  logic          s1_valid_q, s1_valid_d;
  meta_t         s1_meta_q, s1_meta_d;
  logic          out_valid_q, out_valid_d;
  meta_t         out_meta_q;
  logic [7:0]    out_byte_q;

  logic          in_acc, s1_move, is_submit;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  function automatic logic [AW-1:0] bank_addr(sel_t sel, logic [IW-1:0] idx);
    return AW'(AW'(sel) * AW'(FrameBytes)) + AW'(idx);
  endfunction

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_submit  = (op_e'(operation_i) == OP_SUBMIT);

  always_comb begin
    act_sel_d      = act_sel_q;
    pend_sel_d     = pend_sel_q;
    stg_sel_d      = stg_sel_q;
    send_idx_d     = send_idx_q;
    fill_idx_d     = fill_idx_q;
    active_full_d  = active_full_q;
    pending_full_d = pending_full_q;
    sent_cnt_d     = sent_cnt_q;
    ovw_cnt_d      = ovw_cnt_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = bank_addr(stg_sel_q, fill_idx_q);
    ram_raddr      = bank_addr(act_sel_q, send_idx_q);
    s1_meta_d      = s1_meta_q;
    s1_meta_d.tx_valid   = 1'b0;
    s1_meta_d.frame_done = 1'b0;

    if (in_acc) begin
      if (is_submit) begin
        ram_we = 1'b1;
        if (fill_idx_q == LastIdx) begin
          fill_idx_d = '0;
          if (!active_full_q) begin
            stg_sel_d     = act_sel_q;
            act_sel_d     = stg_sel_q;
            active_full_d = 1'b1;
            send_idx_d    = '0;
          end else begin
            if (pending_full_q) begin
              ovw_cnt_d = ovw_cnt_q + 32'd1;
            end
            stg_sel_d      = pend_sel_q;
            pend_sel_d     = stg_sel_q;
            pending_full_d = 1'b1;
          end
        end else begin
          fill_idx_d = fill_idx_q + IW'(1);
        end
      end else if (active_full_q) begin
        ram_re             = 1'b1;
        s1_meta_d.tx_valid = 1'b1;
        if (send_idx_q == LastIdx) begin
          s1_meta_d.frame_done = 1'b1;
          sent_cnt_d = sent_cnt_q + 32'd1;
          send_idx_d = '0;
          if (pending_full_q) begin
            act_sel_d      = pend_sel_q;
            pend_sel_d     = act_sel_q;
            pending_full_d = 1'b0;
          end else begin
            active_full_d = 1'b0;
          end
        end else begin
          send_idx_d = send_idx_q + IW'(1);
        end
      end
      s1_meta_d.busy               = active_full_d || pending_full_d;
      s1_meta_d.frames_sent        = sent_cnt_d;
      s1_meta_d.frames_overwritten = ovw_cnt_d;
    end else begin
      s1_meta_d = s1_meta_q;
    end
  end

  always_comb begin
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  lftdb_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_bank_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_sel_q      <= ACTIVE_SEL_RST;
      pend_sel_q     <= PENDING_SEL_RST;
      stg_sel_q      <= STAGING_SEL_RST;
      send_idx_q     <= '0;
      fill_idx_q     <= '0;
      active_full_q  <= 1'b0;
      pending_full_q <= 1'b0;
      sent_cnt_q     <= '0;
      ovw_cnt_q      <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      act_sel_q      <= act_sel_d;
      pend_sel_q     <= pend_sel_d;
      stg_sel_q      <= stg_sel_d;
      send_idx_q     <= send_idx_d;
      fill_idx_q     <= fill_idx_d;
      active_full_q  <= active_full_d;
      pending_full_q <= pending_full_d;
      sent_cnt_q     <= sent_cnt_d;
      ovw_cnt_q      <= ovw_cnt_d;
      s1_valid_q     <= s1_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_meta_q <= s1_meta_d;
    if (s1_move) begin
      out_meta_q <= s1_meta_q;
      out_byte_q <= s1_meta_q.tx_valid ? ram_rdata : 8'd0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign tx_valid_o           = out_meta_q.tx_valid;
  assign tx_byte_o            = out_byte_q;
  assign frame_done_o         = out_meta_q.frame_done;
  assign busy_res_o           = out_meta_q.busy;
  assign frames_sent_o        = out_meta_q.frames_sent;
  assign frames_overwritten_o = out_meta_q.frames_overwritten;

`ifndef SYNTHESIS
  a_sel_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_sel_q != pend_sel_q) && (act_sel_q != stg_sel_q) && (pend_sel_q != stg_sel_q))
    else $error("bank selectors not distinct");

  a_pend_needs_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_full_q |-> active_full_q)
    else $error("pending frame held without active frame");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free pipeline slot");

  a_done_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_meta_q.frame_done |-> s1_meta_q.tx_valid)
    else $error("frame end without a sent byte");

  a_ovw_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovw_cnt_d != ovw_cnt_q) |-> (in_acc && is_submit && pending_full_q && active_full_q))
    else $error("overwrite count changed without a replaced pending frame");
`endif

endmodule

// File: rtl/lftdb_ram.sv
// ----------------------------------------------------------------------------
// lftdb_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module lftdb_ram #(
  parameter int Width = 8,
  parameter int Depth = 48,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: verif/latest_frame_tx_double_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latest_frame_tx_double_buffer_tb
// Self-checking bench for the latest-frame transmit double buffer.
// A short table of directed requests walks the idle, partial-frame,
// commit-to-active, pending-replace and drain-to-idle paths. Random frame
// traffic mixed with UART ticks follows. Both sides idle at random, and the
// receiver holds off once for a long stretch. Every result is compared field
// by field, against the table for typed rows, else against a bank/selector model.
// ----------------------------------------------------------------------------
module latest_frame_tx_double_buffer_tb;
  import lftdb_pkg::*;

  localparam int FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int HALF_NS      = 5;
  localparam int RANDOM_REQS  = 1650;
  localparam int HOLD_CYCLES  = 240;
  localparam int DRAIN_CYCLES = 12;
  localparam int TIMEOUT_NS   = 8_000_000;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_done;
    logic        busy;
    logic [31:0] sent;
    logic [31:0] overwritten;
  } tx_result_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] reps;
    logic [7:0] first;
    logic [7:0] stride;
    logic       typed;
    tx_result_t want;
  } dir_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  op_e         in_op     = OP_SUBMIT;
  logic [7:0]  in_byte   = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        frame_done;
  logic        busy_res;
  logic [31:0] frames_sent;
  logic [31:0] frames_overwritten;

  // frame model state
  logic [7:0]  bank_mem [BANK_COUNT*FRAME_LEN];
  sel_t        act_sel   = ACTIVE_SEL_RST;
  sel_t        pend_sel  = PENDING_SEL_RST;
  sel_t        stage_sel = STAGING_SEL_RST;
  int          send_pos  = 0;
  int          fill_pos  = 0;
  bit          act_full  = 1'b0;
  bit          pend_full = 1'b0;
  logic [31:0] sent_cnt  = '0;
  logic [31:0] ovw_cnt   = '0;

  tx_result_t  awaited_tx [$];
  int          mismatches    = 0;
  int          results_seen  = 0;
  int          bytes_seen    = 0;
  int          frames_seen   = 0;
  int          submits       = 0;
  int          ticks         = 0;
  int          in_stall_cyc  = 0;
  int          requests_done = 0;
  int          send_burst    = 0;
  bit          hold_off_req  = 1'b0;
  bit          hold_off_done = 1'b0;
  dir_row_t    dir_table [13];

  latest_frame_tx_double_buffer #(
    .FrameBytes(FRAME_LEN)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .operation_i         (in_op),
    .data_byte_i         (in_byte),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .tx_valid_o          (tx_valid),
    .tx_byte_o           (tx_byte),
    .frame_done_o        (frame_done),
    .busy_res_o          (busy_res),
    .frames_sent_o       (frames_sent),
    .frames_overwritten_o(frames_overwritten)
  );

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  function automatic tx_result_t predict_tx(input op_e op, input logic [7:0] b);
    tx_result_t r;
    sel_t       t;
    r = '0;
    if (op == OP_SUBMIT) begin
      bank_mem[stage_sel*FRAME_LEN + fill_pos] = b;
      if (fill_pos + 1 >= FRAME_LEN) begin
        fill_pos = 0;
        if (!act_full) begin
          t = stage_sel; stage_sel = act_sel; act_sel = t;
          act_full = 1'b1;
          send_pos = 0;
        end else begin
          if (pend_full) ovw_cnt = ovw_cnt + 32'd1;
          t = stage_sel; stage_sel = pend_sel; pend_sel = t;
          pend_full = 1'b1;
        end
      end else begin
        fill_pos = fill_pos + 1;
      end
    end else if (act_full) begin
      r.tx_valid = 1'b1;
      r.tx_byte  = bank_mem[act_sel*FRAME_LEN + send_pos];
      if (send_pos + 1 >= FRAME_LEN) begin
        r.frame_done = 1'b1;
        sent_cnt     = sent_cnt + 32'd1;
        send_pos     = 0;
        if (pend_full) begin
          t = act_sel; act_sel = pend_sel; pend_sel = t;
          pend_full = 1'b0;
        end else begin
          act_full = 1'b0;
        end
      end else begin
        send_pos = send_pos + 1;
      end
    end
    r.busy        = act_full | pend_full;
    r.sent        = sent_cnt;
    r.overwritten = ovw_cnt;
    return r;
  endfunction

  function automatic int pick_idle(input bit rx_side);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return rx_side ? $urandom_range(20, 60) : $urandom_range(15, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  // One request; returns after the edge that accepts it and any idle gap that follows.
  task automatic issue_request(input op_e op, input logic [7:0] b, input bit typed,
                               input tx_result_t want);
    tx_result_t exp_r;
    int         gap;
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= b;
    do @(negedge clk); while (in_stall);
    exp_r = predict_tx(op, b);
    awaited_tx.push_back(typed ? want : exp_r);
    if (op == OP_SUBMIT) submits++;
    else ticks++;
    @(posedge clk);
    requests_done++;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(30, 100);
      gap = pick_idle(1'b0);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result check, sampled mid-cycle ahead of the accepting edge.
  always @(negedge clk) begin
    tx_result_t e;
    if (rst_n && in_valid && in_stall) in_stall_cyc++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (tx_valid) bytes_seen++;
      if (frame_done) frames_seen++;
      if (awaited_tx.size() == 0) begin
        report_mismatch("unexpected result", {24'd0, tx_byte}, 32'd0);
      end else begin
        e = awaited_tx.pop_front();
        if (tx_valid !== e.tx_valid)
          report_mismatch("tx_valid", 32'(tx_valid), 32'(e.tx_valid));
        if (tx_byte !== e.tx_byte)
          report_mismatch("tx_byte", 32'(tx_byte), 32'(e.tx_byte));
        if (frame_done !== e.frame_done)
          report_mismatch("frame_done", 32'(frame_done), 32'(e.frame_done));
        if (busy_res !== e.busy)
          report_mismatch("busy_res", 32'(busy_res), 32'(e.busy));
        if (frames_sent !== e.sent) report_mismatch("frames_sent", frames_sent, e.sent);
        if (frames_overwritten !== e.overwritten)
          report_mismatch("frames_overwritten", frames_overwritten, e.overwritten);
      end
    end
  end

  // UART side: random stall pattern plus one long hold-off on request.
  initial begin : uart_side
    int n;
    int len;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_off_req  = 1'b0;
        hold_off_done = 1'b1;
        len = 0;
      end else if ($urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      end else begin
        out_stall <= 1'b1;
        len = pick_idle(1'b1);
        if (len == 0) len = 1;
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin : frame_side
    int         i;
    int         k;
    int         kind;
    int         tick_pct;
    logic [7:0] b;
    dir_table[0]  = '{OP_TICK,   8'd1,  8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 32'd0}};
    dir_table[1]  = '{OP_TICK,   8'd1,  8'hFF, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 32'd0}};
    dir_table[2]  = '{OP_SUBMIT, 8'd1,  8'h00, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 32'd0}};
    dir_table[3]  = '{OP_TICK,   8'd1,  8'hA5, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 32'd0, 32'd0}};
    dir_table[4]  = '{OP_SUBMIT, 8'd14, 8'hFF, 8'hF0, 1'b0, '0};
    dir_table[5]  = '{OP_SUBMIT, 8'd1,  8'h80, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 32'd0, 32'd0}};
    dir_table[6]  = '{OP_TICK,   8'd1,  8'h5A, 8'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1, 32'd0, 32'd0}};
    dir_table[7]  = '{OP_TICK,   8'd3,  8'h00, 8'h01, 1'b0, '0};
    dir_table[8]  = '{OP_SUBMIT, 8'd16, 8'h01, 8'h02, 1'b0, '0};
    dir_table[9]  = '{OP_SUBMIT, 8'd16, 8'h7F, 8'h11, 1'b0, '0};
    dir_table[10] = '{OP_TICK,   8'd12, 8'hC3, 8'h07, 1'b0, '0};
    dir_table[11] = '{OP_TICK,   8'd16, 8'h3C, 8'h0B, 1'b0, '0};
    dir_table[12] = '{OP_TICK,   8'd1,  8'hFF, 8'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0, 32'd2, 32'd1}};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle ticks, partial frame, commit to active, pending replace, drain
    for (i = 0; i < 13; i++) begin
      b = dir_table[i].first;
      for (k = 0; k < dir_table[i].reps; k++) begin
        issue_request(dir_table[i].op, b, dir_table[i].typed, dir_table[i].want);
        b = b + dir_table[i].stride;
      end
    end

    // random: mostly whole frames with ticks, also tick bursts, partial frames, noise
    requests_done = 0;
    while (requests_done < RANDOM_REQS) begin
      if (!hold_off_done && !hold_off_req && requests_done > 400) hold_off_req = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        case ($urandom_range(0, 2))
          0: tick_pct = 0;
          1: tick_pct = 25;
          default: tick_pct = 65;
        endcase
        for (k = 0; k < FRAME_LEN; k++) begin
          if ($urandom_range(0, 99) < tick_pct)
            issue_request(OP_TICK, 8'($urandom), 1'b0, '0);
          issue_request(OP_SUBMIT, 8'($urandom), 1'b0, '0);
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 40)) issue_request(OP_TICK, 8'($urandom), 1'b0, '0);
      end else if (kind < 93) begin
        repeat ($urandom_range(1, FRAME_LEN - 1))
          issue_request(OP_SUBMIT, 8'($urandom), 1'b0, '0);
      end else begin
        issue_request($urandom_range(0, 1) ? OP_TICK : OP_SUBMIT, 8'($urandom), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (awaited_tx.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d submits, %0d ticks, %0d results, %0d bytes to UART, %0d frames done",
             submits, ticks, results_seen, bytes_seen, frames_seen);
    $display("Run: %0d frames overwritten, %0d input stall cycles, %0d mismatches",
             ovw_cnt, in_stall_cyc, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still awaited", awaited_tx.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
